@@ src/md4_pkg.sv @@
`default_nettype none

package md4_pkg;

    // chaining value after reset and after every digest
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;

    // round constants of rounds two and three
    localparam logic [31:0] K_R2 = 32'h5A827999;
    localparam logic [31:0] K_R3 = 32'h6ED9EBA1;

    localparam logic [31:0] PAD_MARKER      = 32'h00000080;
    localparam logic [2:0]  FULL_WORD_BYTES = 3'd4;
    localparam logic [5:0]  LAST_STEP       = 6'd47;
    localparam logic [3:0]  LEN_LO_POS      = 4'd14;
    localparam logic [3:0]  LAST_POS        = 4'd15;
    localparam logic [1:0]  QUEUE_DEPTH     = 2'd2;

    localparam logic [1:0] RND_ONE = 2'd0;
    localparam logic [1:0] RND_TWO = 2'd1;

    localparam logic [4:0] SHIFT_R1 [4] = '{5'd3, 5'd7, 5'd11, 5'd19};
    localparam logic [4:0] SHIFT_R2 [4] = '{5'd3, 5'd5, 5'd9, 5'd13};
    localparam logic [4:0] SHIFT_R3 [4] = '{5'd3, 5'd9, 5'd11, 5'd15};

    // one classified word between front and back
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        last;
    } md4_item_t;

    function automatic logic [31:0] md4_rotl(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] dbl;
        begin
            dbl = {v, v} << s;
            md4_rotl = dbl[63:32];
        end
    endfunction

    // message word used by a given step
    function automatic logic [3:0] md4_msg_index(input logic [5:0] step);
        logic [3:0] i;
        begin
            i = step[3:0];
            unique case (step[5:4])
                RND_ONE: md4_msg_index = i;
                RND_TWO: md4_msg_index = {i[1:0], i[3:2]};
                default: md4_msg_index = {i[0], i[1], i[2], i[3]};
            endcase
        end
    endfunction

    // new b of one compression step
    function automatic logic [31:0] md4_step(
        input logic [31:0] a,
        input logic [31:0] b,
        input logic [31:0] c,
        input logic [31:0] d,
        input logic [31:0] x,
        input logic [5:0]  step
    );
        logic [31:0] f;
        logic [31:0] kc;
        logic [4:0]  s;
        logic [1:0]  j;
        begin
            j = step[1:0];
            unique case (step[5:4])
                RND_ONE:
                begin
                    f  = (b & c) | (~b & d);
                    kc = 32'h0;
                    s  = SHIFT_R1[j];
                end
                RND_TWO:
                begin
                    f  = (b & c) | (b & d) | (c & d);
                    kc = K_R2;
                    s  = SHIFT_R2[j];
                end
                default:
                begin
                    f  = b ^ c ^ d;
                    kc = K_R3;
                    s  = SHIFT_R3[j];
                end
            endcase
            md4_step = md4_rotl(a + f + x + kc, s);
        end
    endfunction

endpackage

`default_nettype wire

@@ src/md4_front.sv @@
`default_nettype none

module md4_front
    import md4_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] data_word,
    input  wire logic [2:0]  byte_count,
    input  wire logic        last_word,
    output logic             q_valid,
    output md4_item_t        q_item,
    input  wire logic        q_pop
);

    md4_item_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    logic       push;
    logic [2:0] n_sat;
    md4_item_t  cls;

    // classify: byte count, masking and the end marker of a short last word
    always_comb
    begin
        n_sat = (byte_count > FULL_WORD_BYTES) ? FULL_WORD_BYTES : byte_count;
        cls.last   = last_word;
        cls.nbytes = last_word ? n_sat : FULL_WORD_BYTES;
        cls.word   = data_word;
        if (last_word)
        begin
            unique case (n_sat)
                3'd0:    cls.word = PAD_MARKER;
                3'd1:    cls.word = {16'h0, PAD_MARKER[7:0], data_word[7:0]};
                3'd2:    cls.word = {8'h0, PAD_MARKER[7:0], data_word[15:0]};
                3'd3:    cls.word = {PAD_MARKER[7:0], data_word[23:0]};
                default: cls.word = data_word;
            endcase
        end
    end

    assign in_stall = (cnt_reg == QUEUE_DEPTH);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

@@ src/md4_back.sv @@
`default_nettype none

module md4_back
    import md4_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire md4_item_t   q_item,
    output logic             q_pop,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      digest_low,
    output logic [63:0]      digest_high
);

    typedef enum logic [2:0] {
        ST_ACCEPT,
        ST_PAD,
        ST_COMPRESS,
        ST_ADD,
        ST_OUTPUT
    } back_state_t;

    back_state_t state_reg, state_next;
    back_state_t ret_reg, ret_next;
    logic [3:0]  wib_reg, wib_next;
    logic [5:0]  step_reg, step_next;
    logic [60:0] total_reg, total_next;
    logic        pad80_reg, pad80_next;
    logic        final_reg, final_next;
    logic [31:0] cva_reg, cva_next, cvb_reg, cvb_next;
    logic [31:0] cvc_reg, cvc_next, cvd_reg, cvd_next;
    logic [31:0] wa_reg, wa_next, wb_reg, wb_next;
    logic [31:0] wc_reg, wc_next, wd_reg, wd_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] dig_lo_reg, dig_lo_next, dig_hi_reg, dig_hi_next;

    logic [31:0] blk_reg [16];
    logic        buf_we;
    logic [31:0] buf_wd;
    logic [31:0] msg_x;
    logic [63:0] len_bits;
    logic        done;

    assign msg_x    = blk_reg[md4_msg_index(step_reg)];
    assign len_bits = {total_reg, 3'b000};

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        wib_next       = wib_reg;
        step_next      = step_reg;
        total_next     = total_reg;
        pad80_next     = pad80_reg;
        final_next     = final_reg;
        cva_next       = cva_reg;
        cvb_next       = cvb_reg;
        cvc_next       = cvc_reg;
        cvd_next       = cvd_reg;
        wa_next        = wa_reg;
        wb_next        = wb_reg;
        wc_next        = wc_reg;
        wd_next        = wd_reg;
        dig_lo_next    = dig_lo_reg;
        dig_hi_next    = dig_hi_reg;
        out_valid_next = out_valid_reg && out_stall;
        q_pop          = 1'b0;
        buf_we         = 1'b0;
        buf_wd         = q_item.word;
        done           = 1'b0;

        unique case (state_reg)
            ST_ACCEPT:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    buf_we     = 1'b1;
                    total_next = total_reg + {58'h0, q_item.nbytes};
                    wib_next   = wib_reg + 4'd1;
                    if (q_item.last)
                    begin
                        // a full last word still owes the end marker
                        pad80_next = (q_item.nbytes == FULL_WORD_BYTES);
                        final_next = (q_item.nbytes != FULL_WORD_BYTES) &&
                                     (wib_reg != LEN_LO_POS);
                        ret_next   = ST_PAD;
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        ret_next   = ST_ACCEPT;
                    end
                    if (wib_reg == LAST_POS)
                    begin
                        wa_next    = cva_reg;
                        wb_next    = cvb_reg;
                        wc_next    = cvc_reg;
                        wd_next    = cvd_reg;
                        step_next  = 6'd0;
                        state_next = ST_COMPRESS;
                    end
                end
            end
            ST_PAD:
            begin
                buf_we   = 1'b1;
                wib_next = wib_reg + 4'd1;
                if (pad80_reg)
                begin
                    buf_wd     = PAD_MARKER;
                    pad80_next = 1'b0;
                    final_next = (wib_reg != LEN_LO_POS);
                end
                else if (final_reg && (wib_reg == LEN_LO_POS))
                begin
                    buf_wd = len_bits[31:0];
                end
                else if (final_reg && (wib_reg == LAST_POS))
                begin
                    buf_wd = len_bits[63:32];
                    done   = 1'b1;
                end
                else
                begin
                    buf_wd = 32'h0;
                end
                if (wib_reg == LAST_POS)
                begin
                    // unless this block already holds the length, the next one does
                    final_next = 1'b1;
                    ret_next   = done ? ST_OUTPUT : ST_PAD;
                    wa_next    = cva_reg;
                    wb_next    = cvb_reg;
                    wc_next    = cvc_reg;
                    wd_next    = cvd_reg;
                    step_next  = 6'd0;
                    state_next = ST_COMPRESS;
                end
            end
            ST_COMPRESS:
            begin
                wa_next   = wd_reg;
                wd_next   = wc_reg;
                wc_next   = wb_reg;
                wb_next   = md4_step(wa_reg, wb_reg, wc_reg, wd_reg, msg_x, step_reg);
                step_next = step_reg + 6'd1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                cva_next   = cva_reg + wa_reg;
                cvb_next   = cvb_reg + wb_reg;
                cvc_next   = cvc_reg + wc_reg;
                cvd_next   = cvd_reg + wd_reg;
                state_next = ret_reg;
            end
            ST_OUTPUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    dig_lo_next    = {cvb_reg, cva_reg};
                    dig_hi_next    = {cvd_reg, cvc_reg};
                    cva_next       = IV_A;
                    cvb_next       = IV_B;
                    cvc_next       = IV_C;
                    cvd_next       = IV_D;
                    total_next     = 61'h0;
                    pad80_next     = 1'b0;
                    final_next     = 1'b0;
                    wib_next       = 4'd0;
                    ret_next       = ST_ACCEPT;
                    state_next     = ST_ACCEPT;
                end
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCEPT;
            ret_reg       <= ST_ACCEPT;
            wib_reg       <= 4'd0;
            step_reg      <= 6'd0;
            total_reg     <= 61'h0;
            pad80_reg     <= 1'b0;
            final_reg     <= 1'b0;
            cva_reg       <= IV_A;
            cvb_reg       <= IV_B;
            cvc_reg       <= IV_C;
            cvd_reg       <= IV_D;
            wa_reg        <= 32'h0;
            wb_reg        <= 32'h0;
            wc_reg        <= 32'h0;
            wd_reg        <= 32'h0;
            out_valid_reg <= 1'b0;
            dig_lo_reg    <= 64'h0;
            dig_hi_reg    <= 64'h0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            wib_reg       <= wib_next;
            step_reg      <= step_next;
            total_reg     <= total_next;
            pad80_reg     <= pad80_next;
            final_reg     <= final_next;
            cva_reg       <= cva_next;
            cvb_reg       <= cvb_next;
            cvc_reg       <= cvc_next;
            cvd_reg       <= cvd_next;
            wa_reg        <= wa_next;
            wb_reg        <= wb_next;
            wc_reg        <= wc_next;
            wd_reg        <= wd_next;
            out_valid_reg <= out_valid_next;
            dig_lo_reg    <= dig_lo_next;
            dig_hi_reg    <= dig_hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            blk_reg[wib_reg] <= buf_wd;
        end
    end

    assign out_valid   = out_valid_reg;
    assign digest_low  = dig_lo_reg;
    assign digest_high = dig_hi_reg;

endmodule

`default_nettype wire

@@ src/md4_message_digest.sv @@
// MD4 digest engine. A message arrives as 32-bit words, first byte in bits
// 7:0; words before the last always count four bytes, the last word carries
// 0 to 4 valid bytes (larger counts act as 4) and triggers padding with the
// 0x80 marker, zeros and the 64-bit bit length, then one 128-bit digest item
// (A in digest_low[31:0], B above, C in digest_high[31:0], D above). After the
// digest the engine starts the next message from the initial values. A front
// stage classifies each accepted word into a two-entry queue; the back end
// writes one word a cycle into the block buffer while the queue holds a word
// and no compression runs, and runs the compression at one step per cycle. A
// full 16-word block is written, then takes 48 steps and one chaining add;
// the single round unit bounds the rate. The last word adds padding writes
// and one or two more compressions, then the digest is registered. The
// digest sits in an output register, so new words keep flowing in while it
// waits to be taken.
`default_nettype none

module md4_message_digest
    import md4_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // word channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] data_word,
    input  wire logic [2:0]  byte_count,
    input  wire logic        last_word,
    // digest channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      digest_low,
    output logic [63:0]      digest_high
);

    // queue between the classifier and the compression sequencer
    logic      q_valid;
    logic      q_pop;
    md4_item_t q_item;

    md4_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_word  (data_word),
        .byte_count (byte_count),
        .last_word  (last_word),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    // block buffer, padding, compression rounds and digest register
    md4_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_low  (digest_low),
        .digest_high (digest_high)
    );

endmodule

`default_nettype wire

@@ sim/tb_md4_message_digest.sv @@
`default_nettype none

module tb_md4_message_digest;
    import md4_pkg::*;

    // one digest as it leaves the block
    typedef struct {
        logic [63:0] low;
        logic [63:0] high;
    } digest_t;

    // per-step tables of the three rounds
    localparam int ORDER_R2 [16] = '{0, 4, 8, 12, 1, 5, 9, 13, 2, 6, 10, 14, 3, 7, 11, 15};
    localparam int ORDER_R3 [16] = '{0, 8, 4, 12, 2, 10, 6, 14, 1, 9, 5, 13, 3, 11, 7, 15};
    localparam int ROT_R1 [4] = '{3, 7, 11, 19};
    localparam int ROT_R2 [4] = '{3, 5, 9, 13};
    localparam int ROT_R3 [4] = '{3, 9, 11, 15};

    localparam int WORD_TARGET = 1800;
    localparam int DRAIN_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] data_word = '0;
    logic [2:0]  byte_count = '0;
    logic        last_word = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] digest_low;
    logic [63:0] digest_high;

    // words waiting to be sent, digests waiting to come back
    md4_item_t pending_words [$];
    digest_t   expected_digests [$];

    // predictor state
    logic [31:0] chain_word [4];
    logic [31:0] block_word [16];
    int          block_fill;
    logic [60:0] msg_bytes;

    int word_gap = 0;
    int stall_left = 0;
    int words_taken = 0;
    int messages_sent = 0;
    int digests_checked = 0;
    int mismatches = 0;

    md4_message_digest dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_word   (data_word),
        .byte_count  (byte_count),
        .last_word   (last_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_low  (digest_low),
        .digest_high (digest_high)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // digest predictor
    // ------------------------------------------------------------------

    function automatic logic [31:0] rotate_left(input logic [31:0] v, input int s);
        // shift amounts are 3..19, never zero
        return (v << s) | (v >> (32 - s));
    endfunction

    task automatic restart_chain();
        chain_word[0] = IV_A;
        chain_word[1] = IV_B;
        chain_word[2] = IV_C;
        chain_word[3] = IV_D;
        block_fill = 0;
        msg_bytes = '0;
    endtask

    // 48 steps over the current block, then fold into the chaining value
    task automatic compress_block();
        logic [31:0] a, b, c, d, f, x, k, t;
        int r, i, s;
        a = chain_word[0];
        b = chain_word[1];
        c = chain_word[2];
        d = chain_word[3];
        for (int n = 0; n < 48; n++)
        begin
            r = n / 16;
            i = n % 16;
            if (r == 0)
            begin
                f = (b & c) | (~b & d);
                x = block_word[i];
                k = 32'h0;
                s = ROT_R1[i % 4];
            end
            else if (r == 1)
            begin
                f = (b & c) | (b & d) | (c & d);
                x = block_word[ORDER_R2[i]];
                k = K_R2;
                s = ROT_R2[i % 4];
            end
            else
            begin
                f = b ^ c ^ d;
                x = block_word[ORDER_R3[i]];
                k = K_R3;
                s = ROT_R3[i % 4];
            end
            t = rotate_left(a + f + x + k, s);
            a = d;
            d = c;
            c = b;
            b = t;
        end
        chain_word[0] = chain_word[0] + a;
        chain_word[1] = chain_word[1] + b;
        chain_word[2] = chain_word[2] + c;
        chain_word[3] = chain_word[3] + d;
    endtask

    task automatic append_word(input logic [31:0] w);
        block_word[block_fill] = w;
        block_fill++;
        if (block_fill == 16)
        begin
            compress_block();
            block_fill = 0;
        end
    endtask

    // fold one accepted word into the running hash; a last word closes the message
    task automatic absorb_word(input logic [31:0] w, input logic [2:0] cnt, input logic fin);
        int          n;
        logic [31:0] keep;
        logic [63:0] bit_len;
        digest_t     dg;
        if (!fin)
        begin
            // byte count is ignored on inner words
            msg_bytes = msg_bytes + 61'd4;
            append_word(w);
        end
        else
        begin
            // counts above four act as a full word
            n = (cnt > FULL_WORD_BYTES) ? 4 : int'(cnt);
            msg_bytes = msg_bytes + 61'(n);
            if (n == 4)
            begin
                append_word(w);
                append_word(PAD_MARKER);
            end
            else
            begin
                // bytes above the count are dropped, marker goes right after
                keep = (32'd1 << (8 * n)) - 32'd1;
                append_word((w & keep) | (PAD_MARKER << (8 * n)));
            end
            // no room for the length: pad out and compress an extra block
            if (block_fill > 14)
            begin
                while (block_fill != 0)
                    append_word(32'h0);
            end
            while (block_fill < 14)
                append_word(32'h0);
            bit_len = {msg_bytes, 3'b000};
            append_word(bit_len[31:0]);
            append_word(bit_len[63:32]);
            dg.low  = {chain_word[1], chain_word[0]};
            dg.high = {chain_word[3], chain_word[2]};
            expected_digests.push_back(dg);
            restart_chain();
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // 0: random, 1: all zeros, 2: all ones
    function automatic logic [31:0] pattern_word(input int pattern);
        if (pattern == 1)
            return 32'h0;
        else if (pattern == 2)
            return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    // inner words carry a random, ignored byte count
    task automatic queue_message(input int body, input int pattern,
                                 input logic [2:0] tail_count, input logic [31:0] tail_data);
        md4_item_t it;
        for (int j = 0; j < body; j++)
        begin
            it.word   = pattern_word(pattern);
            it.nbytes = 3'($urandom_range(0, 7));
            it.last   = 1'b0;
            pending_words.push_back(it);
        end
        it.word   = tail_data;
        it.nbytes = tail_count;
        it.last   = 1'b1;
        pending_words.push_back(it);
        messages_sent++;
    endtask

    task automatic build_stimulus();
        int body, pick, pattern;
        // empty message
        queue_message(0, 0, 3'd0, 32'hFFFF_FFFF);
        // partial tails with garbage above the count
        queue_message(0, 0, 3'd1, 32'hFFFF_FFFF);
        queue_message(0, 0, 3'd2, 32'hFFFF_FFFF);
        queue_message(0, 0, 3'd3, 32'hFFFF_FFFF);
        queue_message(0, 0, 3'd4, 32'h0000_0000);
        // counts above four saturate
        queue_message(0, 0, 3'd5, 32'hFFFF_FFFF);
        queue_message(0, 0, 3'd7, 32'hA5A5_5A5A);
        // 56 bytes: marker lands in word 14, length spills into a second block
        queue_message(13, 2, 3'd4, 32'hFFFF_FFFF);

        // random messages, weighted toward the block boundary
        while (pending_words.size() < WORD_TARGET)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                body = $urandom_range(0, 20);
            else if (pick < 9)
                body = 16 * $urandom_range(0, 2) + $urandom_range(12, 15);
            else
                body = $urandom_range(20, 70);
            pattern = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
            queue_message(body, pattern, 3'($urandom_range(0, 7)), pattern_word(pattern));
        end
    endtask

    // stretches without idling on either side
    function automatic bit quiet_phase();
        return ((words_taken / 150) % 4) == 2;
    endfunction

    function automatic int draw_wait();
        return quiet_phase() ? 0 : $urandom_range(0, 11);
    endfunction

    // ------------------------------------------------------------------
    // word driver
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            word_gap <= 0;
            restart_chain();
        end
        else
        begin : drive_words
            md4_item_t nxt;
            // payload on the pins is the item just taken
            if (in_valid && !in_stall)
            begin
                absorb_word(data_word, byte_count, last_word);
                words_taken++;
            end
            // a stalled item holds still
            if (!(in_valid && in_stall))
            begin
                if (word_gap > 0)
                begin
                    in_valid <= 1'b0;
                    word_gap <= word_gap - 1;
                end
                else if (pending_words.size() > 0)
                begin
                    nxt = pending_words.pop_front();
                    data_word  <= nxt.word;
                    byte_count <= nxt.nbytes;
                    last_word  <= nxt.last;
                    in_valid   <= 1'b1;
                    word_gap   <= draw_wait();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // digest monitor
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin : watch_digests
            int      h;
            digest_t want;
            h = stall_left;
            if (out_valid && !out_stall)
            begin
                if (expected_digests.size() == 0)
                begin
                    $error("unexpected digest: low %h high %h", digest_low, digest_high);
                    mismatches++;
                end
                else
                begin
                    want = expected_digests.pop_front();
                    if (digest_low !== want.low)
                    begin
                        $error("digest_low: expected %h, got %h", want.low, digest_low);
                        mismatches++;
                    end
                    if (digest_high !== want.high)
                    begin
                        $error("digest_high: expected %h, got %h", want.high, digest_high);
                        mismatches++;
                    end
                    digests_checked++;
                end
                // stall length before the next digest
                h = draw_wait();
            end
            else if (h > 0)
            begin
                h--;
            end
            stall_left <= h;
            out_stall  <= (h > 0);
        end
    end

    // ------------------------------------------------------------------
    // run control
    // ------------------------------------------------------------------

    initial
    begin
        build_stimulus();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        // all words sent and every digest back
        while (pending_words.size() > 0 || in_valid || expected_digests.size() > 0)
            @(posedge clk);
        // catch any stray digest
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("sent %0d words in %0d messages, %0d digests compared",
                 words_taken, messages_sent, digests_checked);
        $display("covered empty, partial and saturated tails and two-block padding");
        if (mismatches == 0)
            $display("** md4_message_digest: PASSED **");
        else
            $display("** md4_message_digest: FAILED **");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("timeout with %0d digests outstanding", expected_digests.size());
        $display("** md4_message_digest: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
src/md4_pkg.sv
src/md4_front.sv
src/md4_back.sv
src/md4_message_digest.sv
sim/tb_md4_message_digest.sv
